// ----- hw/rtl/glcd_pkg.sv -----
package glcd_pkg;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Display controller command codes
    localparam logic [15:0] CMD_COL_SET   = 16'h002A;
    localparam logic [15:0] CMD_ROW_SET   = 16'h002B;
    localparam logic [15:0] CMD_MEM_WRITE = 16'h002C;

    // Register reset values
    localparam logic [15:0] FONT_COLOR_RST = 16'hFFFF;
    localparam logic [15:0] BACK_COLOR_RST = 16'h0000;
    localparam logic [7:0]  FONT_SIZE_RST  = 8'd16;

    // Supported glyph heights
    localparam logic [7:0] SIZE_12 = 8'd12;
    localparam logic [7:0] SIZE_16 = 8'd16;
    localparam logic [7:0] SIZE_24 = 8'd24;
    localparam logic [7:0] SIZE_32 = 8'd32;
    localparam logic [7:0] SIZE_48 = 8'd48;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FONT_COLOR,
        CFG_BACK_COLOR,
        CFG_FONT_SIZE,
        CFG_OVERLAY
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] font_color;
        logic [15:0] back_color;
        logic [7:0]  font_size;
        logic        overlay_mode;
    } t_cfg;

    typedef enum logic [1:0] {
        JOB_WINDOW,
        JOB_OPAQUE,
        JOB_OVERLAY
    } t_job_kind;

    // One unit of work for the back end
    typedef struct packed {
        t_job_kind   kind;
        logic [15:0] col_first;
        logic [15:0] row_first;
        logic [15:0] col_last;
        logic [15:0] row_last;
        logic [7:0]  bits;      // opaque: pixel bits, overlay: set pixels to draw
        logic [2:0]  last_pix;  // opaque: index of the final pixel
    } t_job;

    // Beat sequence of a window set, plus the colour beat of an overlay pixel
    typedef enum logic [2:0] {
        ST_COL_CMD,
        ST_COL_START,
        ST_COL_END,
        ST_ROW_CMD,
        ST_ROW_START,
        ST_ROW_END,
        ST_MEM_CMD,
        ST_COLOR
    } t_win_step;

endpackage

// ----- hw/rtl/glcd_front.sv -----
module glcd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  glcd_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_command,
    input  logic [15:0]      i_x_pos,
    input  logic [15:0]      i_y_pos,
    input  logic [7:0]       i_glyph_bits,
    input  logic             i_q_full,
    output logic             o_push,
    output glcd_pkg::t_job   o_job
);
    import glcd_pkg::*;

    logic [15:0] r_origin_col, n_origin_col;
    logic [15:0] r_pen_col, n_pen_col;
    logic [15:0] r_pen_row, n_pen_row;
    logic [6:0]  r_pix, n_pix;

    logic [6:0]  width;
    logic        supported;
    logic [7:0]  cnt;
    logic [6:0]  rem;
    logic [3:0]  take;
    logic        row_end;
    logic [7:0]  pix_mask;
    logic [7:0]  set_bits;
    logic        accept;
    logic        emit;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && emit;

    // Classify the item and work out how many pixels of this byte land in the row
    always_comb begin
        width     = i_cfg.font_size[7:1];
        supported = (i_cfg.font_size == SIZE_12) || (i_cfg.font_size == SIZE_16) ||
                    (i_cfg.font_size == SIZE_24) || (i_cfg.font_size == SIZE_32) ||
                    (i_cfg.font_size == SIZE_48);
        cnt = {1'b0, r_pix} + 8'd1;
        rem = width - r_pix;
        if (cnt >= {1'b0, width}) begin
            take    = 4'd1;
            row_end = 1'b1;
        end else if (rem <= 7'd8) begin
            take    = rem[3:0];
            row_end = 1'b1;
        end else begin
            take    = 4'd8;
            row_end = 1'b0;
        end
        pix_mask = 8'hFF >> (4'd8 - take);
        set_bits = i_glyph_bits & pix_mask;

        o_job.kind      = JOB_WINDOW;
        o_job.col_first = i_x_pos;
        o_job.row_first = i_y_pos;
        o_job.col_last  = 16'(i_x_pos + {9'b0, width} - 16'd1);
        o_job.row_last  = 16'(i_y_pos + {8'b0, i_cfg.font_size} - 16'd1);
        o_job.bits      = i_glyph_bits;
        o_job.last_pix  = 3'(take - 4'd1);
        emit            = 1'b0;

        n_origin_col = r_origin_col;
        n_pen_col    = r_pen_col;
        n_pen_row    = r_pen_row;
        n_pix        = r_pix;

        if (!i_command) begin
            emit         = 1'b1;
            n_origin_col = i_x_pos;
            n_pen_col    = i_x_pos;
            n_pen_row    = i_y_pos;
            n_pix        = '0;
        end else if (supported) begin
            o_job.col_first = r_pen_col;
            o_job.row_first = r_pen_row;
            if (i_cfg.overlay_mode) begin
                o_job.kind = JOB_OVERLAY;
                o_job.bits = set_bits;
                emit       = (set_bits != 8'd0);
            end else begin
                o_job.kind = JOB_OPAQUE;
                emit       = 1'b1;
            end
            // Advance the pen; a finished row returns to the origin column
            if (row_end) begin
                n_pen_col = r_origin_col;
                n_pen_row = r_pen_row + 16'd1;
                n_pix     = '0;
            end else begin
                n_pen_col = r_pen_col + 16'd8;
                n_pix     = r_pix + 7'd8;
            end
        end
    end

    // Hold the pen state between beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_col <= '0;
            r_pen_col    <= '0;
            r_pen_row    <= '0;
            r_pix        <= '0;
        end else if (accept) begin
            r_origin_col <= n_origin_col;
            r_pen_col    <= n_pen_col;
            r_pen_row    <= n_pen_row;
            r_pix        <= n_pix;
        end
    end

endmodule

// ----- hw/rtl/glcd_queue.sv -----
module glcd_queue #(
    parameter int DEPTH = glcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  glcd_pkg::t_job   i_job,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output glcd_pkg::t_job   o_job
);
    import glcd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_job   = r_mem[r_rd];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- hw/rtl/glcd_back.sv -----
module glcd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  glcd_pkg::t_cfg   i_cfg,
    input  logic             i_job_valid,
    input  glcd_pkg::t_job   i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [15:0]      o_word,
    output logic             o_is_command,
    output logic             o_last
);
    import glcd_pkg::*;

    t_win_step   r_step, n_step;
    logic [2:0]  r_pix, n_pix;
    logic [7:0]  r_taken, n_taken;
    logic        r_valid, n_valid;
    logic [15:0] r_word, n_word;
    logic        r_cmd, n_cmd;
    logic        r_last, n_last;

    logic [7:0]  remain;
    logic [7:0]  pick;
    logic [2:0]  idx;
    logic [15:0] ov_col;
    logic [15:0] c1, c2, r1, r2;
    logic        advance;
    logic        emit;
    logic        beat_cmd;
    logic [15:0] beat_word;
    logic        job_last;

    assign o_valid      = r_valid;
    assign o_word       = r_word;
    assign o_is_command = r_cmd;
    assign o_last       = r_last;

    assign advance = !r_valid || i_ready;
    assign emit    = advance && i_job_valid;
    assign o_pop   = emit && job_last;

    // Build the next beat of the head job
    always_comb begin
        remain = i_job.bits & ~r_taken;
        pick   = remain & (~remain + 8'd1);
        idx    = '0;
        for (int i = 0; i < 8; i++) begin
            if (pick[i]) begin
                idx = 3'(i);
            end
        end
        ov_col = i_job.col_first + {13'b0, idx};

        if (i_job.kind == JOB_OVERLAY) begin
            c1 = ov_col;
            c2 = ov_col;
            r1 = i_job.row_first;
            r2 = i_job.row_first;
        end else begin
            c1 = i_job.col_first;
            c2 = i_job.col_last;
            r1 = i_job.row_first;
            r2 = i_job.row_last;
        end

        unique case (r_step)
            ST_COL_CMD:   begin beat_cmd = 1'b1; beat_word = CMD_COL_SET;   end
            ST_COL_START: begin beat_cmd = 1'b0; beat_word = c1;            end
            ST_COL_END:   begin beat_cmd = 1'b0; beat_word = c2;            end
            ST_ROW_CMD:   begin beat_cmd = 1'b1; beat_word = CMD_ROW_SET;   end
            ST_ROW_START: begin beat_cmd = 1'b0; beat_word = r1;            end
            ST_ROW_END:   begin beat_cmd = 1'b0; beat_word = r2;            end
            ST_MEM_CMD:   begin beat_cmd = 1'b1; beat_word = CMD_MEM_WRITE; end
            ST_COLOR:     begin beat_cmd = 1'b0; beat_word = i_cfg.font_color; end
        endcase

        n_step  = r_step;
        n_pix   = r_pix;
        n_taken = r_taken;

        unique case (i_job.kind)
            JOB_WINDOW: begin
                job_last = (r_step == ST_MEM_CMD);
                n_step   = t_win_step'(r_step + 3'd1);
            end
            JOB_OPAQUE: begin
                beat_cmd  = 1'b0;
                beat_word = i_job.bits[r_pix] ? i_cfg.font_color : i_cfg.back_color;
                job_last  = (r_pix == i_job.last_pix);
                n_pix     = r_pix + 3'd1;
            end
            JOB_OVERLAY: begin
                job_last = (r_step == ST_COLOR) && ((remain & ~pick) == 8'd0);
                if (r_step == ST_COLOR) begin
                    n_step  = ST_COL_CMD;
                    n_taken = r_taken | pick;
                end else begin
                    n_step = t_win_step'(r_step + 3'd1);
                end
            end
            default: begin
                job_last = 1'b1;
            end
        endcase

        // Drop per-job progress once the final beat leaves
        if (job_last) begin
            n_step  = ST_COL_CMD;
            n_pix   = '0;
            n_taken = '0;
        end

        n_valid = r_valid;
        n_word  = r_word;
        n_cmd   = r_cmd;
        n_last  = r_last;
        if (advance) begin
            n_valid = i_job_valid;
            n_word  = beat_word;
            n_cmd   = beat_cmd;
            n_last  = job_last;
        end
    end

    // Advance the sequencer only on an issued beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_COL_CMD;
            r_pix   <= '0;
            r_taken <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (emit) begin
                r_step  <= n_step;
                r_pix   <= n_pix;
                r_taken <= n_taken;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_cmd  <= n_cmd;
        r_last <= n_last;
    end

endmodule

// ----- hw/rtl/glyph_to_lcd_write_stream_core.sv -----
// Glyph to display write stream. A start beat (tuser 0) opens a character
// window at its origin: seven writes (column command, x, x+w-1, row command,
// y, y+h-1, memory-write command), with h the font size and w half of it.
// Each glyph byte beat (tuser 1) is expanded least significant bit first
// until the byte or the pixel row runs out: opaque mode gives one colour
// write per pixel, overlay mode gives a one-pixel window plus a colour write
// per set pixel. Glyph bytes under an unsupported font size give no writes.
// Rate: the output side carries one write per cycle while i_m_tready is high.
// A byte gives up to 8 writes in opaque mode, 8 per set pixel in overlay mode,
// and a start item gives 7. The input side takes one beat per cycle while the
// QUEUE_DEPTH-entry job queue has room. Configuration is to be written by the
// user only while the block is idle (not enforced); o_cfg_ready is always high.
module glyph_to_lcd_write_stream_core #(
    parameter int QUEUE_DEPTH = glcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input items
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [39:0]                   i_s_tdata,   // x_pos[15:0], y_pos[31:16], glyph_bits[39:32]
    input  logic                          i_s_tuser,   // command[0]
    // Bus writes
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [15:0]                   o_m_tdata,   // bus_word[15:0]
    output logic                          o_m_tuser,   // is_command[0]
    output logic                          o_m_tlast,
    // Register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [glcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import glcd_pkg::*;

    t_cfg  r_cfg;
    t_job  front_job;
    t_job  head_job;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    logic  q_full;

    assign o_cfg_ready = 1'b1;

    // Register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.font_color   <= FONT_COLOR_RST;
            r_cfg.back_color   <= BACK_COLOR_RST;
            r_cfg.font_size    <= FONT_SIZE_RST;
            r_cfg.overlay_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FONT_COLOR: r_cfg.font_color   <= i_cfg_data;
                CFG_BACK_COLOR: r_cfg.back_color   <= i_cfg_data;
                CFG_FONT_SIZE:  r_cfg.font_size    <= i_cfg_data[7:0];
                CFG_OVERLAY:    r_cfg.overlay_mode <= i_cfg_data[0];
            endcase
        end
    end

    glcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_command    (i_s_tuser),
        .i_x_pos      (i_s_tdata[15:0]),
        .i_y_pos      (i_s_tdata[31:16]),
        .i_glyph_bits (i_s_tdata[39:32]),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_job        (front_job)
    );

    glcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (head_job)
    );

    glcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job_valid  (q_valid),
        .i_job        (head_job),
        .o_pop        (q_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_word       (o_m_tdata),
        .o_is_command (o_m_tuser),
        .o_last       (o_m_tlast)
    );

`ifndef SYNTH
    // A command beat that closes an item is always the memory-write command
    a_last_cmd_is_mem_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast && o_m_tuser |-> o_m_tdata == CMD_MEM_WRITE)
        else $error("last command beat is not memory write");

    // Back pressure on the input only when the back end has queued work
    a_stall_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> q_valid)
        else $error("input stalled with empty job queue");

    // Reset empties the output stage
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

// ----- dv/glyph_to_lcd_write_stream_core_tb.sv -----
`timescale 1ns / 100ps

module glyph_to_lcd_write_stream_core_tb;
    import glcd_pkg::*;

    localparam int RANDOM_ITEMS    = 390;
    localparam int QUIET_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int PRINT_LIMIT     = 30;

    typedef struct packed {
        logic        is_cmd;
        logic [15:0] word;
        logic        last;
    } t_bus_write;

    // How a stimulus beat is checked: by the predictor, by a typed window, or as silent
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_WINDOW,
        CHK_SILENT
    } t_check_kind;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_check_kind chk;
        logic        cmd;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  bits;
        t_cfg_idx    idx;
        logic [15:0] data;
        logic [15:0] col_end;
        logic [15:0] row_end;
    } t_drow;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // x_pos[15:0], y_pos[31:16], glyph_bits[39:32]
    logic        i_s_tuser;   // command[0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // bus_word[15:0]
    logic        o_m_tuser;   // is_command[0]
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [15:0] i_cfg_data;

    glyph_to_lcd_write_stream_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Register mirror
    logic [15:0] fg_color   = FONT_COLOR_RST;
    logic [15:0] bg_color   = BACK_COLOR_RST;
    logic [7:0]  glyph_h    = FONT_SIZE_RST;
    logic        overlay_on = 1'b0;

    // Pen state of the character being drawn
    logic [15:0] org_x  = '0;
    logic [15:0] cur_x  = '0;
    logic [15:0] cur_y  = '0;
    int          run_px = 0;

    t_bus_write  writes_due[$];
    int          fail_count = 0;
    int          writes_seen = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          hold_offs_asked = 0;
    int          hold_offs_served = 0;

    // Check mode of the beat currently offered, set alongside its data
    t_check_kind cur_check;
    logic [15:0] cur_col_end;
    logic [15:0] cur_row_end;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit draws_pixels(input logic [7:0] s);
        return s == SIZE_12 || s == SIZE_16 || s == SIZE_24 || s == SIZE_32 || s == SIZE_48;
    endfunction

    function automatic void push_write(input logic is_cmd, input logic [15:0] word);
        t_bus_write bw;
        bw.is_cmd = is_cmd;
        bw.word   = word;
        bw.last   = 1'b0;
        writes_due.push_back(bw);
    endfunction

    function automatic void push_window(input logic [15:0] c1, r1, c2, r2);
        push_write(1'b1, CMD_COL_SET);
        push_write(1'b0, c1);
        push_write(1'b0, c2);
        push_write(1'b1, CMD_ROW_SET);
        push_write(1'b0, r1);
        push_write(1'b0, r2);
        push_write(1'b1, CMD_MEM_WRITE);
    endfunction

    // Queue the bus writes one input beat causes and advance the pen
    function automatic void expand_item(input logic cmd, input logic [15:0] x, y,
                                        input logic [7:0] bits);
        logic [15:0] half_w;
        logic [15:0] full_h;
        int          w;
        half_w = {8'd0, glyph_h} >> 1;
        full_h = {8'd0, glyph_h};
        w      = glyph_h / 2;
        if (!cmd) begin
            push_window(x, y, x + half_w - 16'd1, y + full_h - 16'd1);
            org_x  = x;
            cur_x  = x;
            cur_y  = y;
            run_px = 0;
        end else if (draws_pixels(glyph_h)) begin
            for (int j = 0; j < 8; j++) begin
                if (!overlay_on) begin
                    push_write(1'b0, bits[j] ? fg_color : bg_color);
                end else if (bits[j]) begin
                    push_window(cur_x, cur_y, cur_x, cur_y);
                    push_write(1'b0, fg_color);
                end
                // End the pixel row once w pixels are out, even mid-byte
                if (run_px + 1 >= w) begin
                    run_px = 0;
                    cur_x  = org_x;
                    cur_y  = cur_y + 16'd1;
                    break;
                end
                run_px = run_px + 1;
                cur_x  = cur_x + 16'd1;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got, want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("ERROR write %0d: %s got %h want %h", writes_seen, what, got, want);
    endtask

    // Check bus writes, predict accepted beats, mirror registers, watch for a hang
    always @(posedge i_clk) begin : scoreboard
        t_bus_write want;
        t_bus_write tail;
        int         n0;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (writes_due.size() == 0) begin
                    report_mismatch("write with none due, tdata", o_m_tdata, 16'h0);
                end else begin
                    want = writes_due.pop_front();
                    if (o_m_tuser !== want.is_cmd)
                        report_mismatch("tuser", {15'd0, o_m_tuser}, {15'd0, want.is_cmd});
                    if (o_m_tdata !== want.word)
                        report_mismatch("tdata", o_m_tdata, want.word);
                    if (o_m_tlast !== want.last)
                        report_mismatch("tlast", {15'd0, o_m_tlast}, {15'd0, want.last});
                end
                writes_seen++;
            end

            if (i_s_tvalid && o_s_tready) begin
                n0 = writes_due.size();
                expand_item(i_s_tuser, i_s_tdata[15:0], i_s_tdata[31:16], i_s_tdata[39:32]);
                // Typed rows replace what was predicted, the pen state stays
                if (cur_check != CHK_MODEL) begin
                    while (writes_due.size() > n0)
                        tail = writes_due.pop_back();
                    if (cur_check == CHK_WINDOW)
                        push_window(i_s_tdata[15:0], i_s_tdata[31:16], cur_col_end, cur_row_end);
                end
                if (writes_due.size() > n0) begin
                    tail = writes_due.pop_back();
                    tail.last = 1'b1;
                    writes_due.push_back(tail);
                end
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FONT_COLOR: fg_color   = i_cfg_data;
                    CFG_BACK_COLOR: bg_color   = i_cfg_data;
                    CFG_FONT_SIZE:  glyph_h    = i_cfg_data[7:0];
                    CFG_OVERLAY:    overlay_on = i_cfg_data[0];
                    default: ;
                endcase
            end

            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ERROR no beat moved for %0d cycles", STALL_LIMIT);
                $display("glyph_to_lcd_write_stream_core: mismatch");
                $finish;
            end
        end
    end

    // Receiver: segments of always-ready, random and periodic stalls, plus long hold-offs
    initial begin : stall_pattern
        int seg_len;
        int seg_mode;
        int period;
        i_m_tready = 1'b0;
        forever begin
            seg_len  = $urandom_range(8, 60);
            seg_mode = $urandom_range(0, 2);
            period   = $urandom_range(2, 5);
            for (int k = 0; k < seg_len; k++) begin
                @(negedge i_clk);
                case (seg_mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= ($urandom_range(0, 3) != 0);
                    default: i_m_tready <= (k % period == 0);
                endcase
            end
            if (hold_offs_served < hold_offs_asked) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_offs_served++;
            end
        end
    end

    // Offer one beat, with a random gap at the start of each burst
    task automatic offer_item(input logic cmd, input logic [15:0] x, y, input logic [7:0] bits,
                              input t_check_kind chk, input logic [15:0] col_end, row_end);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid  <= 1'b1;
        i_s_tuser   <= cmd;
        i_s_tdata   <= {bits, y, x};
        cur_check   <= chk;
        cur_col_end <= col_end;
        cur_row_end <= row_end;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Stop offering, drain every due write, then let trailing silent beats retire
    task automatic settle_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (writes_due.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_drow item_row(input logic cmd, input logic [15:0] x, y,
                                       input logic [7:0] bits);
        t_drow r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.chk  = CHK_MODEL;
        r.cmd  = cmd;
        r.x    = x;
        r.y    = y;
        r.bits = bits;
        return r;
    endfunction

    function automatic t_drow window_row(input logic [15:0] x, y, col_end, row_end);
        t_drow r;
        r         = item_row(1'b0, x, y, 8'h00);
        r.chk     = CHK_WINDOW;
        r.col_end = col_end;
        r.row_end = row_end;
        return r;
    endfunction

    function automatic t_drow silent_row(input logic [7:0] bits);
        t_drow r;
        r     = item_row(1'b1, 16'h0, 16'h0, bits);
        r.chk = CHK_SILENT;
        return r;
    endfunction

    function automatic t_drow reg_row(input t_cfg_idx idx, input logic [15:0] data);
        t_drow r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_bits();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        t_drow       script[$];
        logic [7:0]  size_pick;
        logic [15:0] data;
        logic        cmd;
        int          items_done;
        int          phase;
        int          phase_len;
        int          n;
        int          nbytes;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FONT_COLOR;
        i_cfg_data  = '0;
        cur_check   = CHK_MODEL;
        cur_col_end = '0;
        cur_row_end = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset origin, wrap at both ends, colour extremes, row split mid-byte,
        // overlay with empty bytes, unsupported and odd sizes, shrink below the pen count
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'hA5));
        script.push_back(window_row(16'h0000, 16'h0000, 16'h0007, 16'h000F));
        script.push_back(item_row(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'h00));
        script.push_back(window_row(16'hFFFF, 16'hFFFF, 16'h0006, 16'h000E));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'h81));
        script.push_back(reg_row(CFG_FONT_COLOR, 16'h0000));
        script.push_back(reg_row(CFG_BACK_COLOR, 16'hFFFF));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'h5A));
        script.push_back(reg_row(CFG_FONT_SIZE, {8'd0, SIZE_12}));
        script.push_back(window_row(16'd100, 16'd200, 16'd105, 16'd211));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'hFF));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'h3C));
        script.push_back(reg_row(CFG_OVERLAY, 16'h0001));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'h01));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'h00));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'h80));
        script.push_back(reg_row(CFG_FONT_SIZE, {8'd0, SIZE_48}));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'hFF));
        script.push_back(reg_row(CFG_FONT_SIZE, 16'h0000));
        script.push_back(window_row(16'd1234, 16'd5678, 16'd1233, 16'd5677));
        script.push_back(silent_row(8'hFF));
        script.push_back(reg_row(CFG_FONT_SIZE, 16'h00FF));
        script.push_back(window_row(16'hFFFF, 16'h0000, 16'h007D, 16'h00FE));
        script.push_back(silent_row(8'h0F));
        script.push_back(reg_row(CFG_FONT_SIZE, {8'd0, SIZE_32}));
        script.push_back(reg_row(CFG_OVERLAY, 16'h0000));
        script.push_back(reg_row(CFG_FONT_COLOR, 16'hFFFF));
        script.push_back(reg_row(CFG_BACK_COLOR, 16'h0000));
        script.push_back(window_row(16'h0008, 16'h0010, 16'h0017, 16'h002F));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'hF0));
        script.push_back(reg_row(CFG_FONT_SIZE, {8'd0, SIZE_12}));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'hAA));
        script.push_back(reg_row(CFG_OVERLAY, 16'h0001));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'hFF));
        script.push_back(reg_row(CFG_FONT_SIZE, {8'd0, SIZE_24}));
        script.push_back(reg_row(CFG_OVERLAY, 16'h0000));
        script.push_back(window_row(16'h7FFF, 16'h8000, 16'h800A, 16'h8017));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'h55));
        script.push_back(item_row(1'b1, 16'h0, 16'h0, 8'h00));

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                settle_idle();
                write_reg(script[i].idx, script[i].data);
            end else begin
                offer_item(script[i].cmd, script[i].x, script[i].y, script[i].bits,
                           script[i].chk, script[i].col_end, script[i].row_end);
            end
        end

        // Random phases: new settings, then mostly whole characters with some noise
        items_done = 0;
        phase      = 0;
        while (items_done < RANDOM_ITEMS) begin
            settle_idle();
            if ($urandom_range(0, 1)) write_reg(CFG_FONT_COLOR, pick_color());
            if ($urandom_range(0, 1)) write_reg(CFG_BACK_COLOR, pick_color());
            if (phase == 0 || $urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4:   size_pick = SIZE_12;
                    5, 6, 7, 8, 9:   size_pick = SIZE_16;
                    10, 11:          size_pick = SIZE_24;
                    12, 13:          size_pick = SIZE_32;
                    14, 15:          size_pick = SIZE_48;
                    16:              size_pick = 8'd0;
                    17:              size_pick = 8'd255;
                    default:         size_pick = 8'($urandom);
                endcase
                write_reg(CFG_FONT_SIZE, {8'd0, size_pick});
            end
            if ($urandom_range(0, 1)) begin
                data = 16'($urandom_range(0, 1));
                write_reg(CFG_OVERLAY, data);
            end

            phase_len = $urandom_range(30, 50);
            n = 0;
            while (n < phase_len) begin
                // Hold the receiver off once while beats keep coming
                if (phase >= 1 && n >= 4 && hold_offs_asked == 0)
                    hold_offs_asked++;
                // Pause the sender until every write has come out
                if (n == phase_len / 2 && (phase == 2 || $urandom_range(0, 2) == 0))
                    settle_idle();
                if ($urandom_range(0, 9) < 8) begin
                    offer_item(1'b0, 16'($urandom), 16'($urandom), 8'($urandom),
                               CHK_MODEL, '0, '0);
                    n++;
                    if ($urandom_range(0, 7) == 0) begin
                        nbytes = glyph_h * ((glyph_h / 2 + 7) / 8);
                        if (nbytes > 48) nbytes = 48;
                    end else begin
                        nbytes = $urandom_range(1, 12);
                    end
                    repeat (nbytes) begin
                        offer_item(1'b1, 16'($urandom), 16'($urandom), pick_bits(),
                                   CHK_MODEL, '0, '0);
                        n++;
                    end
                end else begin
                    cmd = 1'($urandom_range(0, 1));
                    offer_item(cmd, 16'($urandom), 16'($urandom), 8'($urandom),
                               CHK_MODEL, '0, '0);
                    n++;
                end
            end
            items_done += n;
            phase++;
        end

        settle_idle();
        if (writes_due.size() != 0)
            report_mismatch("writes never seen, count", 16'(writes_due.size()), 16'h0);
        if (fail_count == 0)
            $display("glyph_to_lcd_write_stream_core: match");
        else
            $display("glyph_to_lcd_write_stream_core: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/glcd_pkg.sv
hw/rtl/glcd_front.sv
hw/rtl/glcd_queue.sv
hw/rtl/glcd_back.sv
hw/rtl/glyph_to_lcd_write_stream_core.sv
dv/glyph_to_lcd_write_stream_core_tb.sv
